### rtl/core/cap_charge_time_sensor_top_assert.svh
// Assertion macros used by the checker file of the sensor.
`ifndef CAP_CHARGE_TIME_SENSOR_TOP_ASSERT_SVH
`define CAP_CHARGE_TIME_SENSOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CCT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sensor assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sensor assertion failed");

`endif

### rtl/core/cct_pkg.sv
`default_nettype none
package cct_pkg;

   localparam int COUNT_BITS = 31;
   localparam int ROUND_W    = 16;
   localparam int DIV_CNT_W  = $clog2(COUNT_BITS + 1);

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [ROUND_W-1:0]    round_type;

   localparam count_type TIMEOUT_RESET  = count_type'(40000000);
   localparam round_type SAMPLES_RESET  = round_type'(30);
   localparam round_type CAL_MS_RESET   = round_type'(1000);

   // Operation codes on the request channel.
   localparam logic [1:0] OP_NONE      = 2'd0;
   localparam logic [1:0] OP_MEASURE   = 2'd1;
   localparam logic [1:0] OP_CALIBRATE = 2'd2;

   // Receive pin drive codes.
   localparam logic [1:0] DRIVE_RELEASED = 2'd0;
   localparam logic [1:0] DRIVE_LOW      = 2'd1;
   localparam logic [1:0] DRIVE_HIGH     = 2'd2;

   // Status codes.
   localparam logic [1:0] ST_OK           = 2'd0;
   localparam logic [1:0] ST_TIMEOUT      = 2'd1;
   localparam logic [1:0] ST_ZERO_SAMPLES = 2'd2;
   localparam logic [1:0] ST_ZERO_ROUNDS  = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] REG_TIMEOUT = 2'd0;
   localparam logic [1:0] REG_SAMPLES = 2'd1;
   localparam logic [1:0] REG_CAL_MS  = 2'd2;

   typedef struct packed {
      logic      start;
      count_type dividend;
      round_type divisor;
   } div_req_type;

   typedef struct packed {
      logic      done;
      count_type quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

### rtl/core/cct_divider.sv
`default_nettype none
module cct_divider
   import cct_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   round_type            rem_ff, rem_in;
   round_type            divisor_ff, divisor_in;
   count_type            qd_ff, qd_in;

   logic [ROUND_W:0]     rem_shift;
   logic [ROUND_W:0]     rem_diff;
   logic                 fits;

   // One restoring step per cycle: the dividend shifts out at the top of qd_ff
   // while quotient bits shift in at the bottom.
   always_comb begin
      rem_shift = {rem_ff, qd_ff[COUNT_BITS-1]};
      rem_diff  = rem_shift - {1'b0, divisor_ff};
      fits      = rem_shift >= {1'b0, divisor_ff};

      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      qd_in      = qd_ff;

      if (div_req.start) begin
         busy_in    = 1'b1;
         count_in   = DIV_CNT_W'(COUNT_BITS);
         rem_in     = '0;
         divisor_in = div_req.divisor;
         qd_in      = div_req.dividend;
      end else if (busy_ff) begin
         rem_in   = fits ? rem_diff[ROUND_W-1:0] : rem_shift[ROUND_W-1:0];
         qd_in    = {qd_ff[COUNT_BITS-2:0], fits};
         count_in = count_ff - DIV_CNT_W'(1);
         if (count_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      qd_ff      <= qd_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = qd_ff;

endmodule
`default_nettype wire

### rtl/core/cap_charge_time_sensor_top.sv
`default_nettype none
// Channel   Direction  Handshake               Payload
// req_      in         req_valid / req_stall   op, rx_level, ms_tick
// rsp_      out        rsp_valid / rsp_stall   send_level, rx_drive, busy_res, done_res,
//                                              value, status
// csr_      in         csr_valid / csr_ready   csr_index, csr_data
//
// One item a cycle is taken while rsp_ is drained and the divider is not working.
// The item that closes a calibration starts the restoring divider, which
// retires one quotient bit a cycle; its quotient is then sent on rsp_.
// Synchronous active-high reset; no memory, so there is no clearing pass.
// req_stall is high while the divider works and while a result waits on rsp_stall.
module cap_charge_time_sensor_top
   import cct_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire logic [1:0]       req_op,
   input  wire logic             req_rx_level,
   input  wire logic             req_ms_tick,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      logic             rsp_send_level,
   output      logic [1:0]       rsp_rx_drive,
   output      logic             rsp_busy_res,
   output      logic             rsp_done_res,
   output      logic [COUNT_BITS-1:0] rsp_value,
   output      logic [1:0]       rsp_status,
   input  wire logic             csr_valid,
   output      logic             csr_ready,
   input  wire logic [1:0]       csr_index,
   input  wire logic [COUNT_BITS-1:0] csr_data
);

   localparam logic [2:0] PH_IDLE       = 3'd0;
   localparam logic [2:0] PH_DISCHARGE  = 3'd1;
   localparam logic [2:0] PH_COUNT_LOW  = 3'd2;
   localparam logic [2:0] PH_CHARGE     = 3'd3;
   localparam logic [2:0] PH_COUNT_HIGH = 3'd4;

   count_type   timeout_ff;
   round_type   samples_ff;
   round_type   cal_ms_ff;

   logic [2:0]  phase_ff, phase_in;
   count_type   tick_total_ff, tick_total_in;
   round_type   sample_index_ff, sample_index_in;
   round_type   round_count_ff, round_count_in;
   round_type   ms_elapsed_ff, ms_elapsed_in;
   logic        calibrating_ff, calibrating_in;
   logic        wait_ff, wait_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_send_ff;
   logic [1:0]  rsp_drive_ff;
   logic        rsp_busy_ff;
   logic        rsp_done_ff;
   count_type   rsp_value_ff;
   logic [1:0]  rsp_status_ff;

   logic        accept;
   logic        load_step;
   logic        step_send;
   logic [1:0]  step_drive;
   logic        step_busy;
   logic        step_done;
   count_type   step_value;
   logic [1:0]  step_status;
   logic        div_start;

   round_type   ms_next;
   round_type   sample_next;
   round_type   round_next;
   count_type   tick_inc;
   logic        over_limit;
   logic        inc_over_limit;

   div_req_type div_req;
   div_rsp_type div_rsp;

   assign req_stall = wait_ff | (rsp_valid_ff & rsp_stall);
   assign accept    = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      ms_next = ms_elapsed_ff;
      if (calibrating_ff && req_ms_tick && ms_elapsed_ff != '1) begin
         ms_next = ms_elapsed_ff + round_type'(1);
      end
      sample_next    = sample_index_ff + round_type'(1);
      round_next     = (round_count_ff != '1) ? round_count_ff + round_type'(1)
                                              : round_count_ff;
      tick_inc       = tick_total_ff + count_type'(1);
      over_limit     = tick_total_ff >= timeout_ff;
      inc_over_limit = tick_inc >= timeout_ff;

      phase_in        = phase_ff;
      tick_total_in   = tick_total_ff;
      sample_index_in = sample_index_ff;
      round_count_in  = round_count_ff;
      ms_elapsed_in   = ms_elapsed_ff;
      calibrating_in  = calibrating_ff;

      step_send   = 1'b0;
      step_drive  = DRIVE_RELEASED;
      step_busy   = 1'b0;
      step_done   = 1'b0;
      step_value  = '0;
      step_status = ST_OK;
      div_start   = 1'b0;

      if (accept) begin
         unique case (phase_ff)
            PH_DISCHARGE: begin
               ms_elapsed_in = ms_next;
               phase_in      = PH_COUNT_LOW;
               step_drive    = DRIVE_LOW;
               step_busy     = 1'b1;
            end
            PH_COUNT_LOW: begin
               ms_elapsed_in = ms_next;
               if (over_limit) begin
                  phase_in       = PH_IDLE;
                  calibrating_in = 1'b0;
                  step_done      = 1'b1;
                  step_status    = ST_TIMEOUT;
               end else if (!req_rx_level) begin
                  tick_total_in = tick_inc;
                  if (inc_over_limit) begin
                     phase_in       = PH_IDLE;
                     calibrating_in = 1'b0;
                     step_done      = 1'b1;
                     step_status    = ST_TIMEOUT;
                  end else begin
                     step_send = 1'b1;
                     step_busy = 1'b1;
                  end
               end else begin
                  phase_in  = PH_CHARGE;
                  step_send = 1'b1;
                  step_busy = 1'b1;
               end
            end
            PH_CHARGE: begin
               ms_elapsed_in = ms_next;
               phase_in      = PH_COUNT_HIGH;
               step_send     = 1'b1;
               step_drive    = DRIVE_HIGH;
               step_busy     = 1'b1;
            end
            PH_COUNT_HIGH: begin
               ms_elapsed_in = ms_next;
               if (over_limit) begin
                  phase_in       = PH_IDLE;
                  calibrating_in = 1'b0;
                  step_done      = 1'b1;
                  step_status    = ST_TIMEOUT;
               end else if (req_rx_level) begin
                  tick_total_in = tick_inc;
                  if (inc_over_limit) begin
                     phase_in       = PH_IDLE;
                     calibrating_in = 1'b0;
                     step_done      = 1'b1;
                     step_status    = ST_TIMEOUT;
                  end else begin
                     step_busy = 1'b1;
                  end
               end else begin
                  // End of one sample: next sample, next round, or the result.
                  sample_index_in = sample_next;
                  if (sample_next != '0 && sample_next < samples_ff) begin
                     phase_in  = PH_DISCHARGE;
                     step_busy = 1'b1;
                  end else if (!calibrating_ff) begin
                     phase_in    = PH_IDLE;
                     step_done   = 1'b1;
                     step_value  = tick_total_ff;
                  end else begin
                     round_count_in = round_next;
                     if (ms_next < cal_ms_ff && round_next != '1) begin
                        sample_index_in = '0;
                        phase_in        = PH_DISCHARGE;
                        step_busy       = 1'b1;
                     end else begin
                        // The baseline arrives from the divider once its division is done.
                        phase_in       = PH_IDLE;
                        calibrating_in = 1'b0;
                        div_start      = 1'b1;
                     end
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
               if (req_op == OP_MEASURE || req_op == OP_CALIBRATE) begin
                  calibrating_in  = req_op == OP_CALIBRATE;
                  tick_total_in   = '0;
                  sample_index_in = '0;
                  round_count_in  = '0;
                  ms_elapsed_in   = '0;
                  if (samples_ff == '0) begin
                     calibrating_in = 1'b0;
                     step_done      = 1'b1;
                     step_status    = ST_ZERO_SAMPLES;
                  end else if (req_op == OP_CALIBRATE && cal_ms_ff == '0) begin
                     calibrating_in = 1'b0;
                     step_done      = 1'b1;
                     step_status    = ST_ZERO_ROUNDS;
                  end else begin
                     phase_in   = PH_COUNT_LOW;
                     step_drive = DRIVE_LOW;
                     step_busy  = 1'b1;
                  end
               end
            end
         endcase
      end
   end

   assign load_step = accept & ~div_start;

   always_comb begin
      wait_in = wait_ff;
      if (div_start) begin
         wait_in = 1'b1;
      end else if (div_rsp.done) begin
         wait_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (load_step || div_rsp.done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign div_req.start    = div_start;
   assign div_req.dividend = tick_total_ff;
   assign div_req.divisor  = round_next;

   cct_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff      <= TIMEOUT_RESET;
         samples_ff      <= SAMPLES_RESET;
         cal_ms_ff       <= CAL_MS_RESET;
         phase_ff        <= PH_IDLE;
         tick_total_ff   <= '0;
         sample_index_ff <= '0;
         round_count_ff  <= '0;
         ms_elapsed_ff   <= '0;
         calibrating_ff  <= 1'b0;
         wait_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_TIMEOUT: timeout_ff <= csr_data;
               REG_SAMPLES: samples_ff <= csr_data[ROUND_W-1:0];
               REG_CAL_MS:  cal_ms_ff  <= csr_data[ROUND_W-1:0];
               default: ;
            endcase
         end
         phase_ff        <= phase_in;
         tick_total_ff   <= tick_total_in;
         sample_index_ff <= sample_index_in;
         round_count_ff  <= round_count_in;
         ms_elapsed_ff   <= ms_elapsed_in;
         calibrating_ff  <= calibrating_in;
         wait_ff         <= wait_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_step) begin
         rsp_send_ff   <= step_send;
         rsp_drive_ff  <= step_drive;
         rsp_busy_ff   <= step_busy;
         rsp_done_ff   <= step_done;
         rsp_value_ff  <= step_value;
         rsp_status_ff <= step_status;
      end else if (div_rsp.done) begin
         rsp_send_ff   <= 1'b0;
         rsp_drive_ff  <= DRIVE_RELEASED;
         rsp_busy_ff   <= 1'b0;
         rsp_done_ff   <= 1'b1;
         rsp_value_ff  <= div_rsp.quotient;
         rsp_status_ff <= ST_OK;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_send_level = rsp_send_ff;
   assign rsp_rx_drive   = rsp_drive_ff;
   assign rsp_busy_res   = rsp_busy_ff;
   assign rsp_done_res   = rsp_done_ff;
   assign rsp_value      = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;

endmodule
`default_nettype wire

### rtl/core/cct_checker.sv
`default_nettype none
`include "cap_charge_time_sensor_top_assert.svh"
module cct_checker
   import cct_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_stall,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic                  rsp_send_level,
   input wire logic [1:0]            rsp_rx_drive,
   input wire logic                  rsp_busy_res,
   input wire logic                  rsp_done_res,
   input wire logic [COUNT_BITS-1:0] rsp_value,
   input wire logic [1:0]            rsp_status
);

   logic rsp_held;
   logic pins_quiet;
   logic no_payload;
   logic charge_ok;

   assign rsp_held   = rsp_valid && rsp_stall;
   assign pins_quiet = !rsp_busy_res && !rsp_send_level && (rsp_rx_drive == DRIVE_RELEASED);
   assign no_payload = (rsp_value == '0) && (rsp_status == ST_OK);
   assign charge_ok  = rsp_send_level && rsp_busy_res;

   // A result that is held back keeps its value.
   `CCT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_value))

   // The item that ends a run leaves both pins quiet and the block idle.
   `CCT_ASSERT_NOW(a_done_quiet, clock, reset, rsp_valid && rsp_done_res, pins_quiet)

   // Without a finished run there is no value and no status.
   `CCT_ASSERT_NOW(a_idle_zero, clock, reset, rsp_valid && !rsp_done_res, no_payload)

   // The receive pin is only driven high during the charge step, with send high.
   `CCT_ASSERT_NOW(a_charge_send, clock, reset, rsp_valid && rsp_rx_drive == DRIVE_HIGH, charge_ok)

   // A waiting result blocks the request side.
   `CCT_ASSERT_NOW(a_back_pressure, clock, reset, rsp_held, req_stall)

endmodule

bind cap_charge_time_sensor_top cct_checker u_checker (.*);
`default_nettype wire

### tb/sv/tb_top.sv
`default_nettype none
module tb_top
   import cct_pkg::*;
();

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam count_type COUNT_MAX = '1;
   localparam round_type ROUND_MAX = '1;

   typedef enum logic [2:0] {
      SENSE_IDLE,
      SENSE_DISCHARGE,
      SENSE_COUNT_LOW,
      SENSE_CHARGE,
      SENSE_COUNT_HIGH
   } sense_phase_type;

   typedef struct packed {
      logic       send_level;
      logic [1:0] rx_drive;
      logic       busy_res;
      logic       done_res;
      count_type  value;
      logic [1:0] status;
   } tick_result_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_op = OP_NONE;
   logic       req_rx_level = 1'b0;
   logic       req_ms_tick = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_send_level;
   logic [1:0] rsp_rx_drive;
   logic       rsp_busy_res;
   logic       rsp_done_res;
   count_type  rsp_value;
   logic [1:0] rsp_status;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = REG_TIMEOUT;
   count_type  csr_data = '0;

   // Shadow of the sensor state and its registers.
   sense_phase_type run_phase = SENSE_IDLE;
   logic            calibrating = 1'b0;
   count_type       total_ticks = '0;
   round_type       sample_idx = '0;
   round_type       rounds_done = '0;
   round_type       ms_seen = '0;
   count_type       cfg_timeout = TIMEOUT_RESET;
   round_type       cfg_samples = SAMPLES_RESET;
   round_type       cfg_cal_ms = CAL_MS_RESET;

   tick_result_type expected_ticks[$];
   int              error_count = 0;
   int              hold_count = 0;
   logic            gaps_on = 1'b1;

   cap_charge_time_sensor_top DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_rx_level   (req_rx_level),
      .req_ms_tick    (req_ms_tick),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_send_level (rsp_send_level),
      .rsp_rx_drive   (rsp_rx_drive),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_value      (rsp_value),
      .rsp_status     (rsp_status),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic tick_result_type close_run(input count_type val, input logic [1:0] st);
      tick_result_type r;
      r = '0;
      run_phase = SENSE_IDLE;
      calibrating = 1'b0;
      r.done_res = 1'b1;
      r.value = val;
      r.status = st;
      return r;
   endfunction

   task automatic predict_tick(input logic [1:0] op, input logic rx, input logic ms);
      tick_result_type r;
      r = '0;
      if (run_phase == SENSE_IDLE) begin
         if (op == OP_MEASURE || op == OP_CALIBRATE) begin
            calibrating = (op == OP_CALIBRATE);
            total_ticks = '0;
            sample_idx = '0;
            rounds_done = '0;
            ms_seen = '0;
            if (cfg_samples == 0) begin
               r = close_run('0, ST_ZERO_SAMPLES);
            end else if (calibrating && cfg_cal_ms == 0) begin
               r = close_run('0, ST_ZERO_ROUNDS);
            end else begin
               // The start tick already discharges the receive pin.
               run_phase = SENSE_COUNT_LOW;
               r.rx_drive = DRIVE_LOW;
               r.busy_res = 1'b1;
            end
         end
      end else begin
         if (calibrating && ms && ms_seen != ROUND_MAX) ms_seen++;
         case (run_phase)
            SENSE_DISCHARGE: begin
               run_phase = SENSE_COUNT_LOW;
               r.rx_drive = DRIVE_LOW;
               r.busy_res = 1'b1;
            end
            SENSE_COUNT_LOW: begin
               if (total_ticks >= cfg_timeout) begin
                  r = close_run('0, ST_TIMEOUT);
               end else if (!rx) begin
                  total_ticks = total_ticks + 1'b1;
                  if (total_ticks >= cfg_timeout) begin
                     r = close_run('0, ST_TIMEOUT);
                  end else begin
                     r.send_level = 1'b1;
                     r.busy_res = 1'b1;
                  end
               end else begin
                  run_phase = SENSE_CHARGE;
                  r.send_level = 1'b1;
                  r.busy_res = 1'b1;
               end
            end
            SENSE_CHARGE: begin
               run_phase = SENSE_COUNT_HIGH;
               r.send_level = 1'b1;
               r.rx_drive = DRIVE_HIGH;
               r.busy_res = 1'b1;
            end
            default: begin
               if (total_ticks >= cfg_timeout) begin
                  r = close_run('0, ST_TIMEOUT);
               end else if (rx) begin
                  total_ticks = total_ticks + 1'b1;
                  if (total_ticks >= cfg_timeout) r = close_run('0, ST_TIMEOUT);
                  else r.busy_res = 1'b1;
               end else begin
                  // The pin has dropped: this sample is complete.
                  sample_idx = sample_idx + 1'b1;
                  if (sample_idx != 0 && sample_idx < cfg_samples) begin
                     run_phase = SENSE_DISCHARGE;
                     r.busy_res = 1'b1;
                  end else if (!calibrating) begin
                     r = close_run(total_ticks, ST_OK);
                  end else begin
                     if (rounds_done != ROUND_MAX) rounds_done++;
                     if (ms_seen < cfg_cal_ms && rounds_done != ROUND_MAX) begin
                        sample_idx = '0;
                        run_phase = SENSE_DISCHARGE;
                        r.busy_res = 1'b1;
                     end else begin
                        r = close_run(count_type'(total_ticks / rounds_done), ST_OK);
                     end
                  end
               end
            end
         endcase
      end
      expected_ticks.push_back(r);
   endtask

   task automatic check_field(input string name, input count_type want, input count_type got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   task automatic check_result();
      tick_result_type want;
      if (expected_ticks.size() == 0) begin
         $error("result arrived with no item outstanding");
         error_count++;
      end else begin
         want = expected_ticks.pop_front();
         check_field("send_level", count_type'(want.send_level), count_type'(rsp_send_level));
         check_field("rx_drive", count_type'(want.rx_drive), count_type'(rsp_rx_drive));
         check_field("busy_res", count_type'(want.busy_res), count_type'(rsp_busy_res));
         check_field("done_res", count_type'(want.done_res), count_type'(rsp_done_res));
         check_field("value", want.value, rsp_value);
         check_field("status", count_type'(want.status), count_type'(rsp_status));
      end
   endtask

   // Result side: checks every accepted item and drives the stall pattern.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_valid && !rsp_stall) check_result();
            if (hold_count > 0) begin
               rsp_stall <= 1'b1;
               hold_count--;
            end else begin
               rsp_stall <= gaps_on && ($urandom_range(0, 99) < 13);
            end
         end
      end
   end

   task automatic send_tick(input logic [1:0] op, input logic rx, input logic ms);
      while (gaps_on && $urandom_range(0, 99) < 13) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_rx_level <= rx;
      req_ms_tick <= ms;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_tick(op, rx, ms);
   endtask

   task automatic write_reg(input logic [1:0] idx, input count_type data);
      count_type word;
      word = data;
      // The upper bits of the narrow registers must be ignored.
      if (idx != REG_TIMEOUT) word[COUNT_BITS-1:ROUND_W] = (COUNT_BITS-ROUND_W)'($urandom);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= word;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         REG_TIMEOUT: cfg_timeout = word;
         REG_SAMPLES: cfg_samples = word[ROUND_W-1:0];
         default:     cfg_cal_ms = word[ROUND_W-1:0];
      endcase
      @(posedge clock);
   endtask

   // Models the RC pin: while counting, the level holds with stay_pct chance.
   function automatic logic pin_level(input int stay_pct);
      if ($urandom_range(0, 99) < 10) return 1'($urandom_range(0, 1));
      case (run_phase)
         SENSE_COUNT_LOW:  return !($urandom_range(0, 99) < stay_pct);
         SENSE_COUNT_HIGH: return ($urandom_range(0, 99) < stay_pct);
         default:          return 1'($urandom_range(0, 1));
      endcase
   endfunction

   task automatic random_tick(input int stay_pct, input int ms_pct);
      logic [1:0] op;
      if (run_phase == SENSE_IDLE) begin
         if ($urandom_range(0, 99) < 80) op = $urandom_range(0, 1) ? OP_MEASURE : OP_CALIBRATE;
         else op = 2'($urandom_range(0, 3));
      end else begin
         op = ($urandom_range(0, 99) < 90) ? OP_NONE : 2'($urandom_range(0, 3));
      end
      send_tick(op, pin_level(stay_pct), $urandom_range(0, 99) < ms_pct);
   endtask

   task automatic run_to_idle(input int stay_pct, input logic ms);
      while (run_phase != SENSE_IDLE) send_tick(OP_NONE, pin_level(stay_pct), ms);
   endtask

   // Finishes any run, then waits for every outstanding result.
   task automatic settle();
      int waited;
      while (run_phase != SENSE_IDLE)
         send_tick(OP_NONE, pin_level(50), $urandom_range(0, 99) < 30);
      req_valid <= 1'b0;
      waited = 0;
      while (expected_ticks.size() != 0 && waited < 50000) begin
         @(posedge clock);
         waited++;
      end
      if (expected_ticks.size() != 0) begin
         $error("%0d results never arrived", expected_ticks.size());
         error_count++;
         expected_ticks.delete();
      end
      repeat (COUNT_BITS + 4) @(posedge clock);
   endtask

   task automatic test_reset_settings();
      send_tick(OP_MEASURE, 1'b0, 1'b0);
      run_to_idle(30, 1'b0);
      settle();
   endtask

   task automatic test_commands_and_corners();
      send_tick(OP_NONE, 1'b0, 1'b0);
      send_tick(OP_UNUSED, 1'b1, 1'b1);
      settle();
      write_reg(REG_SAMPLES, count_type'(0));
      send_tick(OP_MEASURE, 1'b1, 1'b0);
      send_tick(OP_CALIBRATE, 1'b0, 1'b1);
      settle();
      write_reg(REG_SAMPLES, count_type'(1));
      write_reg(REG_CAL_MS, count_type'(0));
      send_tick(OP_CALIBRATE, 1'b0, 1'b0);
      // One sample: two ticks low, one tick high; commands while busy are ignored.
      send_tick(OP_MEASURE, 1'b0, 1'b0);
      send_tick(OP_CALIBRATE, 1'b0, 1'b0);
      send_tick(OP_NONE, 1'b0, 1'b1);
      send_tick(OP_MEASURE, 1'b1, 1'b0);
      send_tick(OP_UNUSED, 1'b0, 1'b0);
      send_tick(OP_NONE, 1'b1, 1'b0);
      send_tick(OP_NONE, 1'b0, 1'b0);
      settle();
      write_reg(REG_TIMEOUT, count_type'(1));
      send_tick(OP_MEASURE, 1'b1, 1'b1);
      send_tick(OP_NONE, 1'b0, 1'b0);
      settle();
      write_reg(REG_TIMEOUT, COUNT_MAX);
      write_reg(REG_CAL_MS, count_type'(1));
      send_tick(OP_CALIBRATE, 1'b0, 1'b1);
      send_tick(OP_NONE, 1'b0, 1'b1);
      send_tick(OP_NONE, 1'b1, 1'b0);
      send_tick(OP_NONE, 1'b1, 1'b0);
      send_tick(OP_NONE, 1'b0, 1'b0);
      settle();
   endtask

   task automatic test_register_extremes();
      write_reg(REG_TIMEOUT, count_type'(40));
      write_reg(REG_SAMPLES, count_type'(ROUND_MAX));
      write_reg(REG_CAL_MS, count_type'(ROUND_MAX));
      send_tick(OP_MEASURE, 1'b0, 1'b0);
      run_to_idle(60, 1'b0);
      send_tick(OP_CALIBRATE, 1'b0, 1'b1);
      run_to_idle(60, 1'b1);
      settle();
   endtask

   task automatic test_backpressure();
      write_reg(REG_TIMEOUT, COUNT_MAX);
      write_reg(REG_SAMPLES, count_type'(4));
      write_reg(REG_CAL_MS, count_type'(3));
      hold_count = 400;
      for (int n = 0; n < 150; n++) random_tick(60, 20);
      settle();
   endtask

   task automatic random_setting();
      int samples;
      int cal_ms;
      count_type limit;
      if ($urandom_range(0, 9) == 0) samples = $urandom_range(0, 1) ? 0 : int'(ROUND_MAX);
      else samples = $urandom_range(1, 4);
      if ($urandom_range(0, 9) == 0) cal_ms = $urandom_range(0, 1) ? 0 : int'(ROUND_MAX);
      else cal_ms = $urandom_range(1, 6);
      // Long settings are only reachable with a short timeout.
      if (samples > 8 || cal_ms > 8 || $urandom_range(0, 2) == 0)
         limit = count_type'($urandom_range(1, 120));
      else if ($urandom_range(0, 1))
         limit = COUNT_MAX;
      else
         limit = count_type'($urandom_range(200, 32'h4000_0000));
      write_reg(REG_TIMEOUT, limit);
      write_reg(REG_SAMPLES, count_type'(samples));
      write_reg(REG_CAL_MS, count_type'(cal_ms));
   endtask

   task automatic test_random_runs();
      int stay_pct;
      int ms_pct;
      for (int p = 0; p < 12; p++) begin
         random_setting();
         gaps_on = (p != 5);
         stay_pct = $urandom_range(40, 85);
         ms_pct = $urandom_range(5, 50);
         for (int n = 0; n < 60; n++) random_tick(stay_pct, ms_pct);
         settle();
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_settings();
      test_commands_and_corners();
      test_register_extremes();
      test_backpressure();
      test_random_runs();
      settle();
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
`default_nettype wire

### cap_charge_time_sensor_top.f
+incdir+rtl/core
rtl/core/cct_pkg.sv
rtl/core/cct_divider.sv
rtl/core/cap_charge_time_sensor_top.sv
rtl/core/cct_checker.sv
tb/sv/tb_top.sv
